// File: design/kvca_pkg.sv
// ----------------------------------------------------------------------------
// kvca_pkg
// Shared types, constants and elaboration helpers for the key/value cache
// attention block.
// ----------------------------------------------------------------------------
`default_nettype none

package kvca_pkg;

    // default geometry
    localparam int HEADS_DEF       = 2;
    localparam int HEAD_DIM_DEF    = 3;
    localparam int MAX_CONTEXT_DEF = 16;

    // stream payload widths
    localparam int IN_DATA_W  = 32;
    localparam int OUT_DATA_W = 24;

    // field widths
    localparam int POS_W   = 4;
    localparam int ELEM_W  = 5;
    localparam int VAL_W   = 16;
    localparam int HIDX_W  = 1;
    localparam int DIDX_W  = 2;

    // fixed point constants
    localparam int          WGT_W     = 17;
    localparam logic [12:0] LOG2E_Q12 = 13'd5909;

    // 2^(-k/16) in q1.16
    localparam logic [WGT_W-1:0] EXP2_FRAC [0:15] = '{
        17'd65536, 17'd62757, 17'd60097, 17'd57549,
        17'd55109, 17'd52773, 17'd50536, 17'd48393,
        17'd46341, 17'd44376, 17'd42495, 17'd40693,
        17'd38968, 17'd37316, 17'd35734, 17'd34219
    };

    // sequencer states
    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SC_RD,
        ST_SC_MUL,
        ST_SC_ACC,
        ST_SC_SCL,
        ST_SC_RND,
        ST_WT_RD,
        ST_WT_MUL,
        ST_WT_EXP,
        ST_OV_RD,
        ST_OV_MUL,
        ST_OV_ACC,
        ST_DV_GO,
        ST_DIV,
        ST_EMIT
    } t_state;

    // index width of at least one bit
    function automatic int clog2m(input int v);
        return (v > 1) ? $clog2(v) : 1;
    endfunction

    // integer square root, used for the score scale at elaboration
    function automatic longint unsigned isqrt_u64(input longint unsigned x);
        longint unsigned rem;
        longint unsigned res;
        longint unsigned bitv;
        rem  = x;
        res  = 0;
        bitv = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (rem >= res + bitv) begin
                rem = rem - (res + bitv);
                res = (res >> 1) + bitv;
            end else begin
                res = res >> 1;
            end
            bitv = bitv >> 2;
        end
        return res;
    endfunction

endpackage

`default_nettype wire

// File: design/kvca_store.sv
// ----------------------------------------------------------------------------
// kvca_store
// Key and value cache memories: one write port, one shared read address,
// registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module kvca_store #(
    parameter int DEPTH = 96,
    parameter int A_W   = 7
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_key_we,
    input  wire logic                          i_val_we,
    input  wire logic [A_W-1:0]                i_wr_addr,
    input  wire logic [kvca_pkg::VAL_W-1:0]    i_wr_data,
    input  wire logic [A_W-1:0]                i_rd_addr,
    output logic signed [kvca_pkg::VAL_W-1:0]  o_key_rdata,
    output logic signed [kvca_pkg::VAL_W-1:0]  o_val_rdata
);

    logic [kvca_pkg::VAL_W-1:0] r_key_mem [DEPTH];
    logic [kvca_pkg::VAL_W-1:0] r_val_mem [DEPTH];

    // key memory
    always_ff @(posedge i_clk) begin
        if (i_key_we) begin
            r_key_mem[i_wr_addr] <= i_wr_data;
        end
        o_key_rdata <= r_key_mem[i_rd_addr];
    end

    // value memory
    always_ff @(posedge i_clk) begin
        if (i_val_we) begin
            r_val_mem[i_wr_addr] <= i_wr_data;
        end
        o_val_rdata <= r_val_mem[i_rd_addr];
    end

endmodule

`default_nettype wire

// File: design/kvca_div.sv
// ----------------------------------------------------------------------------
// kvca_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module kvca_div #(
    parameter int N_W = 39,
    parameter int D_W = 21
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_start,
    input  wire logic [N_W-1:0] i_dividend,
    input  wire logic [D_W-1:0] i_divisor,
    output logic                o_busy,
    output logic                o_done,
    output logic [N_W-1:0]      o_quot
);

    localparam int C_W = $clog2(N_W + 1);

    logic             r_busy;
    logic             r_done;
    logic [C_W-1:0]   r_cnt;
    logic [N_W-1:0]   r_q;
    logic [D_W-1:0]   r_rem;
    logic [D_W-1:0]   r_div;
    logic [D_W:0]     w_rem_sh;
    logic [D_W:0]     w_rem_sub;
    logic             w_qbit;

    // trial subtraction
    always_comb begin
        w_rem_sh  = {r_rem, r_q[N_W-1]};
        w_rem_sub = w_rem_sh - {1'b0, r_div};
        w_qbit    = (w_rem_sh >= {1'b0, r_div});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == C_W'(N_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[N_W-2:0], w_qbit};
            r_rem <= w_qbit ? w_rem_sub[D_W-1:0] : w_rem_sh[D_W-1:0];
        end
    end

    assign o_busy = r_busy;
    assign o_done = r_done;
    assign o_quot = r_q;

endmodule

`default_nettype wire

// File: design/kv_cache_attention_append_top.sv
// ----------------------------------------------------------------------------
// kv_cache_attention_append_top
// Single-token causal attention over a key/value cache, q4.12 fixed point.
// ----------------------------------------------------------------------------
// A token row of 3*HEADS*HEAD_DIM elements (query, keys, values, head-major)
// is taken one element per cycle; keys and values land in the cache at the
// token position. On the row's last element the block stops taking input and
// runs attention head by head with one divider.
// For a token at position p, each head computes scores over positions 0..p,
// then softmax weights, then the outputs one dimension at a time, each
// through the divider, which is ACC_W+1 bits wide (39 with defaults); every
// cache and score access goes through a registered memory read. The
// memories need no clearing; tokens must be written in order from position 0.
// ----------------------------------------------------------------------------
`default_nettype none

module kv_cache_attention_append_top #(
    parameter int HEADS       = kvca_pkg::HEADS_DEF,
    parameter int HEAD_DIM    = kvca_pkg::HEAD_DIM_DEF,
    parameter int MAX_CONTEXT = kvca_pkg::MAX_CONTEXT_DEF
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    // token_pos [3:0], elem_index [8:4], elem_value [24:9], zero fill
    input  wire logic [kvca_pkg::IN_DATA_W-1:0]     s_axis_tdata,
    // row_last
    input  wire logic                               s_axis_tlast,
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // head_index [0], dim_index [2:1], out_value [18:3], zero fill
    output logic [kvca_pkg::OUT_DATA_W-1:0]         m_axis_tdata,
    // out_last
    output logic                                    m_axis_tlast
);

    localparam int M      = HEADS * HEAD_DIM;
    localparam int J_W    = kvca_pkg::clog2m(MAX_CONTEXT);
    localparam int H_W    = kvca_pkg::clog2m(HEADS);
    localparam int D_W    = kvca_pkg::clog2m(HEAD_DIM);
    localparam int Q_W    = kvca_pkg::clog2m(M);
    localparam int A_W    = kvca_pkg::clog2m(MAX_CONTEXT * M);
    localparam int DOT_W  = 32 + $clog2(HEAD_DIM);
    localparam int PRD_W  = DOT_W + 18;
    localparam int SC_W   = PRD_W - 28;
    localparam int T_W    = SC_W + 1;
    localparam int TX_W   = T_W + 13;
    localparam int U_W    = TX_W - 11;
    localparam int W_W    = kvca_pkg::WGT_W;
    localparam int TOT_W  = W_W + J_W;
    localparam int OP_W   = 34;
    localparam int ACC_W  = OP_W + J_W;
    localparam int N_W    = ACC_W + 1;
    localparam longint unsigned SCALE_U =
        kvca_pkg::isqrt_u64((64'd1 << 32) / HEAD_DIM);

    localparam logic signed [17:0] C_SCALE = 18'(SCALE_U);

    // state and counters
    kvca_pkg::t_state r_state;
    kvca_pkg::t_state n_state;
    logic [J_W-1:0]   r_j;
    logic [J_W-1:0]   r_pos;
    logic [D_W-1:0]   r_d;
    logic [H_W-1:0]   r_h;

    // datapath registers
    logic signed [kvca_pkg::VAL_W-1:0] r_qbuf [M];
    logic signed [31:0]                r_prod;
    logic signed [DOT_W-1:0]           r_dot;
    logic signed [PRD_W-1:0]           r_sprod;
    logic signed [SC_W-1:0]            r_mx;
    logic [TX_W-1:0]                   r_tx;
    logic [TOT_W-1:0]                  r_total;
    logic signed [OP_W-1:0]            r_oprod;
    logic signed [ACC_W-1:0]           r_acc;
    logic                              r_neg;
    logic [SC_W-1:0]                   r_sc_mem [MAX_CONTEXT];
    logic [SC_W-1:0]                   r_sc_rdata;

    // output register
    logic                              r_ovalid;
    logic [kvca_pkg::HIDX_W-1:0]       r_ohead;
    logic [kvca_pkg::DIDX_W-1:0]       r_odim;
    logic [kvca_pkg::VAL_W-1:0]        r_oval;
    logic                              r_olast;

    // combinational nets
    logic                              w_accept;
    logic [kvca_pkg::POS_W-1:0]        w_in_pos;
    logic [kvca_pkg::ELEM_W-1:0]       w_in_elem;
    logic [kvca_pkg::VAL_W-1:0]        w_in_val;
    logic [J_W-1:0]                    w_pos;
    logic                              w_key_we;
    logic                              w_val_we;
    logic [A_W-1:0]                    w_wr_addr;
    logic [A_W-1:0]                    w_rd_addr;
    logic [Q_W-1:0]                    w_q_idx;
    logic signed [kvca_pkg::VAL_W-1:0] w_key;
    logic signed [kvca_pkg::VAL_W-1:0] w_val;
    logic signed [PRD_W-1:0]           w_rnd;
    logic signed [SC_W-1:0]            w_score;
    logic signed [SC_W-1:0]            w_sc_old;
    logic [T_W-1:0]                    w_t;
    logic [TX_W:0]                     w_usum;
    logic [U_W-1:0]                    w_u;
    logic [U_W-13:0]                   w_n;
    logic [3:0]                        w_k;
    logic [W_W-1:0]                    w_wgt;
    logic [ACC_W-1:0]                  w_mag;
    logic [N_W-1:0]                    w_dividend;
    logic                              w_div_start;
    logic                              w_div_busy;
    logic                              w_div_done;
    logic [N_W-1:0]                    w_quot;
    logic [kvca_pkg::VAL_W-1:0]        w_sat;
    logic                              w_load;
    logic                              w_d_last;
    logic                              w_h_last;
    logic                              w_j_last;

    // input unpacking and element decode
    always_comb begin
        w_in_pos  = s_axis_tdata[3:0];
        w_in_elem = s_axis_tdata[8:4];
        w_in_val  = s_axis_tdata[24:9];
        w_accept  = s_axis_tvalid && s_axis_tready;
        if (int'(w_in_pos) >= MAX_CONTEXT) begin
            w_pos = J_W'(MAX_CONTEXT - 1);
        end else begin
            w_pos = J_W'(w_in_pos);
        end
        w_key_we = w_accept && (int'(w_in_elem) >= M) && (int'(w_in_elem) < 2 * M);
        w_val_we = w_accept && (int'(w_in_elem) >= 2 * M) && (int'(w_in_elem) < 3 * M);
        if (w_key_we) begin
            w_wr_addr = A_W'(int'(w_pos) * M + int'(w_in_elem) - M);
        end else begin
            w_wr_addr = A_W'(int'(w_pos) * M + int'(w_in_elem) - 2 * M);
        end
    end

    // cache read address and query select
    always_comb begin
        w_rd_addr = A_W'(int'(r_j) * M + int'(r_h) * HEAD_DIM + int'(r_d));
        w_q_idx   = Q_W'(int'(r_h) * HEAD_DIM + int'(r_d));
    end

    kvca_store #(
        .DEPTH (MAX_CONTEXT * M),
        .A_W   (A_W)
    ) u_store (
        .i_clk       (i_clk),
        .i_key_we    (w_key_we),
        .i_val_we    (w_val_we),
        .i_wr_addr   (w_wr_addr),
        .i_wr_data   (w_in_val),
        .i_rd_addr   (w_rd_addr),
        .o_key_rdata (w_key),
        .o_val_rdata (w_val)
    );

    // score rounding and exp weight
    always_comb begin
        w_rnd    = r_sprod + PRD_W'(28'h800_0000);
        w_score  = w_rnd[PRD_W-1:28];
        w_sc_old = r_sc_rdata;
        w_t      = T_W'({r_mx[SC_W-1], r_mx} - {w_sc_old[SC_W-1], w_sc_old});
        w_usum   = {1'b0, r_tx} + (TX_W + 1)'(12'h800);
        w_u      = w_usum[TX_W:12];
        w_n      = w_u[U_W-1:12];
        w_k      = w_u[11:8];
        if (w_n > (U_W - 12)'(16)) begin
            w_wgt = '0;
        end else begin
            w_wgt = kvca_pkg::EXP2_FRAC[w_k] >> w_n[4:0];
        end
    end

    // rounded magnitude for the divider
    always_comb begin
        w_mag      = r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        w_dividend = N_W'(w_mag) + N_W'(r_total >> 1);
    end

    kvca_div #(
        .N_W (N_W),
        .D_W (TOT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_dividend),
        .i_divisor  (r_total),
        .o_busy     (w_div_busy),
        .o_done     (w_div_done),
        .o_quot     (w_quot)
    );

    // sign and saturation of the quotient
    always_comb begin
        if (r_neg) begin
            if (w_quot > N_W'(32768)) begin
                w_sat = 16'h8000;
            end else begin
                w_sat = 16'(-w_quot);
            end
        end else begin
            if (w_quot > N_W'(32767)) begin
                w_sat = 16'h7fff;
            end else begin
                w_sat = w_quot[15:0];
            end
        end
    end

    // next state and strobes
    always_comb begin
        w_d_last    = (r_d == D_W'(HEAD_DIM - 1));
        w_h_last    = (r_h == H_W'(HEADS - 1));
        w_j_last    = (r_j == r_pos);
        w_div_start = (r_state == kvca_pkg::ST_DV_GO);
        w_load      = (r_state == kvca_pkg::ST_EMIT) && (!r_ovalid || m_axis_tready);
        n_state     = r_state;
        case (r_state)
            kvca_pkg::ST_IDLE: begin
                if (w_accept && s_axis_tlast) begin
                    n_state = kvca_pkg::ST_SC_RD;
                end
            end
            kvca_pkg::ST_SC_RD:  n_state = kvca_pkg::ST_SC_MUL;
            kvca_pkg::ST_SC_MUL: n_state = kvca_pkg::ST_SC_ACC;
            kvca_pkg::ST_SC_ACC: begin
                n_state = w_d_last ? kvca_pkg::ST_SC_SCL : kvca_pkg::ST_SC_RD;
            end
            kvca_pkg::ST_SC_SCL: n_state = kvca_pkg::ST_SC_RND;
            kvca_pkg::ST_SC_RND: begin
                n_state = w_j_last ? kvca_pkg::ST_WT_RD : kvca_pkg::ST_SC_RD;
            end
            kvca_pkg::ST_WT_RD:  n_state = kvca_pkg::ST_WT_MUL;
            kvca_pkg::ST_WT_MUL: n_state = kvca_pkg::ST_WT_EXP;
            kvca_pkg::ST_WT_EXP: begin
                n_state = w_j_last ? kvca_pkg::ST_OV_RD : kvca_pkg::ST_WT_RD;
            end
            kvca_pkg::ST_OV_RD:  n_state = kvca_pkg::ST_OV_MUL;
            kvca_pkg::ST_OV_MUL: n_state = kvca_pkg::ST_OV_ACC;
            kvca_pkg::ST_OV_ACC: begin
                n_state = w_j_last ? kvca_pkg::ST_DV_GO : kvca_pkg::ST_OV_RD;
            end
            kvca_pkg::ST_DV_GO:  n_state = kvca_pkg::ST_DIV;
            kvca_pkg::ST_DIV: begin
                if (w_div_done) begin
                    n_state = kvca_pkg::ST_EMIT;
                end
            end
            kvca_pkg::ST_EMIT: begin
                if (w_load) begin
                    if (!w_d_last) begin
                        n_state = kvca_pkg::ST_OV_RD;
                    end else if (!w_h_last) begin
                        n_state = kvca_pkg::ST_SC_RD;
                    end else begin
                        n_state = kvca_pkg::ST_IDLE;
                    end
                end
            end
            default: n_state = kvca_pkg::ST_IDLE;
        endcase
    end

    // state register and loop counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= kvca_pkg::ST_IDLE;
            r_j      <= '0;
            r_d      <= '0;
            r_h      <= '0;
            r_pos    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            case (r_state)
                kvca_pkg::ST_IDLE: begin
                    if (w_accept && s_axis_tlast) begin
                        r_pos <= w_pos;
                        r_j   <= '0;
                        r_d   <= '0;
                        r_h   <= '0;
                    end
                end
                kvca_pkg::ST_SC_ACC: begin
                    r_d <= w_d_last ? '0 : r_d + 1'b1;
                end
                kvca_pkg::ST_SC_RND, kvca_pkg::ST_WT_EXP, kvca_pkg::ST_OV_ACC: begin
                    r_j <= w_j_last ? '0 : r_j + 1'b1;
                end
                kvca_pkg::ST_EMIT: begin
                    if (w_load) begin
                        r_j <= '0;
                        if (!w_d_last) begin
                            r_d <= r_d + 1'b1;
                        end else begin
                            r_d <= '0;
                            if (!w_h_last) begin
                                r_h <= r_h + 1'b1;
                            end
                        end
                    end
                end
                default: begin
                end
            endcase
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // query buffer, taken while the row streams in
    always_ff @(posedge i_clk) begin
        if (w_accept && (int'(w_in_elem) < M)) begin
            r_qbuf[Q_W'(w_in_elem)] <= w_in_val;
        end
    end

    // score / weight memory, registered read
    always_ff @(posedge i_clk) begin
        if (r_state == kvca_pkg::ST_SC_RND) begin
            r_sc_mem[r_j] <= w_score;
        end else if (r_state == kvca_pkg::ST_WT_EXP) begin
            r_sc_mem[r_j] <= SC_W'(w_wgt);
        end
        r_sc_rdata <= r_sc_mem[r_j];
    end

    // arithmetic datapath
    always_ff @(posedge i_clk) begin
        case (r_state)
            kvca_pkg::ST_IDLE: begin
                r_dot <= '0;
            end
            kvca_pkg::ST_SC_MUL: begin
                r_prod <= r_qbuf[w_q_idx] * w_key;
            end
            kvca_pkg::ST_SC_ACC: begin
                r_dot <= r_dot + DOT_W'(r_prod);
            end
            kvca_pkg::ST_SC_SCL: begin
                r_sprod <= r_dot * C_SCALE;
            end
            kvca_pkg::ST_SC_RND: begin
                r_dot   <= '0;
                r_total <= '0;
                if ((r_j == '0) || (w_score > r_mx)) begin
                    r_mx <= w_score;
                end
            end
            kvca_pkg::ST_WT_MUL: begin
                r_tx <= w_t * kvca_pkg::LOG2E_Q12;
            end
            kvca_pkg::ST_WT_EXP: begin
                r_total <= r_total + TOT_W'(w_wgt);
                r_acc   <= '0;
            end
            kvca_pkg::ST_OV_MUL: begin
                r_oprod <= $signed({1'b0, r_sc_rdata[W_W-1:0]}) * w_val;
            end
            kvca_pkg::ST_OV_ACC: begin
                r_acc <= r_acc + ACC_W'(r_oprod);
            end
            kvca_pkg::ST_DV_GO: begin
                r_neg <= r_acc[ACC_W-1];
            end
            kvca_pkg::ST_EMIT: begin
                if (w_load) begin
                    r_acc <= '0;
                    r_dot <= '0;
                end
            end
            default: begin
            end
        endcase
    end

    // output payload
    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_ohead <= r_h[0];
            r_odim  <= kvca_pkg::DIDX_W'(r_d);
            r_oval  <= w_sat;
            r_olast <= w_d_last && w_h_last;
        end
    end

    assign s_axis_tready = (r_state == kvca_pkg::ST_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tlast  = r_olast;
    assign m_axis_tdata  = {5'b0, r_oval, r_odim, r_ohead};

    // divider is only started when free
    a_div_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kvca_pkg::ST_DV_GO) |-> !w_div_busy)
        else $error("divider started while busy");

    // position loop stays within the token's context
    a_j_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != kvca_pkg::ST_IDLE) |-> (r_j <= r_pos))
        else $error("position counter beyond token position");

    // softmax denominator holds at least the weight of the maximum
    a_total_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == kvca_pkg::ST_DV_GO) |-> (r_total >= TOT_W'(65536)))
        else $error("weight sum below unit weight");

    // final output of a token is marked and the sequencer goes idle
    a_last_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_load && w_d_last && w_h_last) |=>
            (r_state == kvca_pkg::ST_IDLE && m_axis_tvalid && m_axis_tlast))
        else $error("last output not marked or sequencer not idle");

endmodule

`default_nettype wire
